// ===== rtl/hcs_pkg.sv =====
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared constants and helpers of the Heun characteristic step block.
// ----------------------------------------------------------------------------
package hcs_pkg;

  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned MAX_OUT   = 8;

  localparam logic [2:0] ACT_BIRTH = 3'd0;
  localparam logic [2:0] ACT_DEATH = 3'd1;
  localparam logic [2:0] ACT_MIGR  = 3'd2;
  localparam logic [2:0] ACT_Q     = 3'd3;
  localparam logic [2:0] ACT_STEP  = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  localparam logic signed [31:0] ONE_Q = 32'sh0100_0000;

  // saturate a 40-bit signed value to 32 bits
  function automatic logic [32:0] sat40(input logic signed [39:0] v);
    logic [32:0] r;
    if (v > 40'sh00_7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -40'sh00_8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/hcs_ram.sv =====
// ----------------------------------------------------------------------------
// hcs_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/hcs_mul.sv =====
// ----------------------------------------------------------------------------
// hcs_mul
// Shared Q8.24 multiplier: registered 33x32 product, then round and clip.
// ----------------------------------------------------------------------------
module hcs_mul import hcs_pkg::*; (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic               half_i,   // shift 25 instead of 24, no clip
  output logic [32:0]        res_o     // {clip, q}, always shifted by 24
  ,output logic signed [39:0] wide_o
);
  logic signed [64:0] prod_q;
  logic               half_q;
  logic signed [64:0] rnd;
  logic signed [64:0] rnd2;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    half_q <= half_i;
  end

  assign rnd  = (prod_q + 65'sd8388608) >>> FRAC_BITS;
  assign rnd2 = (prod_q + 65'sd16777216) >>> (FRAC_BITS + 1);
  assign res_o = sat40(rnd[64:40] == {25{rnd[39]}} ? rnd[39:0]
                       : (rnd[64] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF));
  assign wide_o = half_q ? rnd2[39:0] : rnd[39:0];
endmodule

// ===== rtl/heun_characteristic_step_top.sv =====
// ----------------------------------------------------------------------------
// heun_characteristic_step_top
// Heun step of a birth-death-migration characteristic in Q8.24.
// ----------------------------------------------------------------------------
// After reset the rate, migration and q memories are cleared to zero with
// the input held off. Write items take effect as they are taken; a read
// item gives its result through the q memory read and the output register.
// A step item runs two flow passes on one shared multiplier, every product
// passing a multiply and a round state, the first product of each term
// after a memory read; the birth and each migration term chain two
// products. Then min(STAGES,8) result items leave, each issued only once
// the previous one has been taken. One item is in work at a time.
module heun_characteristic_step_top import hcs_pkg::*; #(
  parameter int unsigned STAGES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // action[2:0], row_index[5:3], column_index[8:6], value[40:9], zero[47:41]
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // vertex[2:0], q_value[34:3], zero[39:35]
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o  // saturated
);
  localparam int unsigned AW  = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int unsigned MAW = 2 * AW;
  localparam int unsigned NOUT = (STAGES < MAX_OUT) ? STAGES : MAX_OUT;
  localparam int unsigned VDEPTH = 1 << AW;
  localparam int unsigned MDEPTH = 1 << MAW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;  // issue read of term
  localparam logic [3:0] S_MUL  = 4'd2;  // operands ready, multiply
  localparam logic [3:0] S_RND  = 4'd3;  // product rounded
  localparam logic [3:0] S_OUT  = 4'd4;
  localparam logic [3:0] S_OUTW = 4'd5;
  localparam logic [3:0] S_RDQ  = 4'd6;
  localparam logic [3:0] S_MUL2 = 4'd7;  // second factor times qi
  localparam logic [3:0] S_RND2 = 4'd8;
  localparam logic [3:0] S_CLR  = 4'd9;  // zero the memories after reset

  // term codes within one vertex of one pass
  localparam logic [1:0] T_BIRTH = 2'd0;
  localparam logic [1:0] T_DEATH = 2'd1;
  localparam logic [1:0] T_MIGR  = 2'd2;
  localparam logic [1:0] T_UPD   = 2'd3;

  logic [3:0]  st_q;
  logic [30:0] dt_q;
  logic        pass_q;           // 0 first flow, 1 second flow
  logic [1:0]  term_q;
  logic [AW-1:0] vi_q, vj_q;
  logic [MAW-1:0] clr_q;
  logic signed [39:0] acc_q;
  logic        fl_q;
  logic [STAGES-1:0] clip_q;
  logic [31:0] qi_q, tmp_q;
  logic [3:0]  oc_q;
  logic        out_v_q;
  logic [2:0]  out_vx_q;
  logic [31:0] out_val_q;
  logic        out_last_q, out_sat_q;
  logic        rd_item_q;

  logic [2:0]  act;
  logic [2:0]  row, col;
  logic [31:0] val;
  logic        acc;
  assign act = s_axis_tdata_i[2:0];
  assign row = s_axis_tdata_i[5:3];
  assign col = s_axis_tdata_i[8:6];
  assign val = s_axis_tdata_i[40:9];
  assign s_axis_tready_o = (st_q == S_IDLE) && !out_v_q;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  logic row_ok, col_ok;
  assign row_ok = (32'(row) < STAGES);
  assign col_ok = (32'(col) < STAGES);

  // memories
  logic          b_we, d_we, m_we, q_we, p_we, f_we;
  logic [AW-1:0] b_wa, q_wa, p_wa, f_wa, ra;
  logic [MAW-1:0] m_wa, m_ra;
  logic [31:0]   b_wd, q_wd, p_wd, f_wd;
  logic [31:0]   b_rd, d_rd, m_rd, q_rd, p_rd, f_rd, qa_rd, pa_rd;
  logic [AW-1:0] ra2;

  hcs_ram #(.Width(32), .Depth(VDEPTH)) u_birth (.clk_i, .we_i(b_we),
    .waddr_i(b_wa), .wdata_i(b_wd), .raddr_i(ra), .rdata_o(b_rd));
  hcs_ram #(.Width(32), .Depth(VDEPTH)) u_death (.clk_i, .we_i(d_we),
    .waddr_i(b_wa), .wdata_i(b_wd), .raddr_i(ra), .rdata_o(d_rd));
  hcs_ram #(.Width(32), .Depth(MDEPTH)) u_migr (.clk_i, .we_i(m_we),
    .waddr_i(m_wa), .wdata_i(b_wd), .raddr_i(m_ra), .rdata_o(m_rd));
  hcs_ram #(.Width(32), .Depth(VDEPTH)) u_q (.clk_i, .we_i(q_we),
    .waddr_i(q_wa), .wdata_i(q_wd), .raddr_i(ra), .rdata_o(q_rd));
  hcs_ram #(.Width(32), .Depth(VDEPTH)) u_qj (.clk_i, .we_i(q_we),
    .waddr_i(q_wa), .wdata_i(q_wd), .raddr_i(ra2), .rdata_o(qa_rd));
  hcs_ram #(.Width(32), .Depth(VDEPTH)) u_pred (.clk_i, .we_i(p_we),
    .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(ra), .rdata_o(p_rd));
  hcs_ram #(.Width(32), .Depth(VDEPTH)) u_predj (.clk_i, .we_i(p_we),
    .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(ra2), .rdata_o(pa_rd));
  hcs_ram #(.Width(32), .Depth(VDEPTH)) u_flux (.clk_i, .we_i(f_we),
    .waddr_i(f_wa), .wdata_i(f_wd), .raddr_i(ra), .rdata_o(f_rd));

  // multiplier operands
  logic signed [32:0] ma;
  logic signed [31:0] mb;
  logic               mhalf;
  logic [32:0]        mres;
  logic signed [39:0] mwide;
  hcs_mul u_mul (.clk_i, .a_i(ma), .b_i(mb), .half_i(mhalf),
    .res_o(mres), .wide_o(mwide));

  // operand views at S_MUL (memory data valid)
  logic [31:0] qi_cur, qj_cur;
  logic [32:0] qm1, om1;
  assign qi_cur = pass_q ? p_rd : q_rd;
  assign qj_cur = pass_q ? pa_rd : qa_rd;
  assign qm1 = sat40(40'($signed(term_q == T_MIGR ? qj_cur : qi_cur))
                     - 40'(ONE_Q));
  assign om1 = sat40(40'(ONE_Q) - 40'($signed(qi_cur)));

  // predictor adds the clipped increment, corrector the wide one
  logic [32:0] fsat, upd_sat;
  logic signed [39:0] sum_ext, upd_inc;
  assign fsat = sat40(acc_q);
  assign sum_ext = 40'($signed(f_rd)) + 40'($signed(fsat[31:0]));
  assign upd_inc = pass_q ? mwide : 40'($signed(mres[31:0]));
  assign upd_sat = sat40(40'($signed(q_rd)) + upd_inc);

  always_comb begin
    ra = vi_q; ra2 = vj_q;
    m_ra = MAW'({vi_q, vj_q});
    b_we = 1'b0; d_we = 1'b0; m_we = 1'b0; q_we = 1'b0; p_we = 1'b0; f_we = 1'b0;
    b_wa = AW'(row); m_wa = MAW'({AW'(row), AW'(col)});
    b_wd = val; q_wa = AW'(row); q_wd = val;
    p_wa = vi_q; p_wd = upd_sat[31:0]; f_wa = vi_q; f_wd = fsat[31:0];
    ma = '0; mb = '0; mhalf = 1'b0;
    if (st_q == S_CLR) begin
      b_we = 1'b1; d_we = 1'b1; m_we = 1'b1; q_we = 1'b1;
      b_wa = AW'(clr_q); m_wa = clr_q; q_wa = AW'(clr_q);
      b_wd = '0; q_wd = '0;
    end
    if (st_q == S_IDLE && acc) begin
      ra = AW'(row);
      case (act)
        ACT_BIRTH: b_we = row_ok;
        ACT_DEATH: d_we = row_ok;
        ACT_MIGR:  m_we = row_ok && col_ok;
        ACT_Q:     q_we = row_ok;
        default: ;
      endcase
    end
    if (st_q == S_MUL) begin
      case (term_q)
        T_BIRTH: begin ma = 33'($signed(b_rd)); mb = $signed(qm1[31:0]); end
        T_DEATH: begin ma = 33'($signed(d_rd)); mb = $signed(om1[31:0]); end
        T_MIGR:  begin ma = 33'($signed(m_rd)); mb = $signed(qm1[31:0]); end
        default: begin
          // update: predictor or corrector
          if (!pass_q) begin
            ma = 33'($signed(fsat[31:0]));
          end else begin
            ma = sum_ext[32:0];
          end
          mb = $signed({1'b0, dt_q});
          mhalf = pass_q;
        end
      endcase
    end
    if (st_q == S_MUL2) begin
      ma = 33'($signed(tmp_q)); mb = $signed(qi_q);
    end
    // write-back of the update term
    if (st_q == S_RND && term_q == T_UPD) begin
      if (!pass_q) begin
        p_we = 1'b1; f_we = 1'b1;
      end else begin
        q_we = 1'b1; q_wa = vi_q; q_wd = upd_sat[31:0];
      end
    end
    if (st_q == S_OUT || st_q == S_OUTW) ra = AW'(oc_q);
  end

  // corrector sum needs its own saturation check for the wide product
  logic [32:0] corr_sat;
  assign corr_sat = sat40(40'($signed(q_rd)) + mwide);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; dt_q <= 31'd167772; pass_q <= 1'b0; term_q <= T_BIRTH;
      vi_q <= '0; vj_q <= '0; acc_q <= '0; fl_q <= 1'b0; clip_q <= '0;
      oc_q <= '0; out_v_q <= 1'b0; rd_item_q <= 1'b0; clr_q <= '0;
    end else begin
      if (cfg_we_i) dt_q <= cfg_wdata_i;
      if (out_v_q && m_axis_tready_i) out_v_q <= 1'b0;
      case (st_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) st_q <= S_IDLE;
        end
        S_IDLE: if (acc) begin
          if (act == ACT_STEP) begin
            st_q <= S_RD; pass_q <= 1'b0; term_q <= T_BIRTH;
            vi_q <= '0; vj_q <= '0; acc_q <= '0; fl_q <= 1'b0; clip_q <= '0;
          end else if (act == ACT_READ) begin
            st_q <= S_RDQ; out_vx_q <= row;
            rd_item_q <= row_ok;
          end
        end
        S_RDQ: begin
          out_v_q <= 1'b1; out_val_q <= rd_item_q ? q_rd : 32'd0;
          out_last_q <= 1'b1; out_sat_q <= 1'b0; st_q <= S_IDLE;
        end
        S_RD: st_q <= S_MUL;
        S_MUL: begin
          qi_q <= qi_cur;
          if (term_q != T_UPD && (qm1[32] || (term_q == T_DEATH && om1[32])))
            fl_q <= 1'b1;
          st_q <= S_RND;
        end
        S_RND: begin
          if (term_q == T_UPD) begin
            if (!pass_q) begin
              clip_q[vi_q] <= clip_q[vi_q] | fl_q | fsat[32] | mres[32]
                              | upd_sat[32];
            end else begin
              clip_q[vi_q] <= clip_q[vi_q] | fl_q | fsat[32] | corr_sat[32];
            end
            acc_q <= '0; fl_q <= 1'b0; term_q <= T_BIRTH; vj_q <= '0;
            if (32'(vi_q) == STAGES - 1) begin
              vi_q <= '0;
              if (pass_q) begin
                st_q <= S_OUT; oc_q <= '0;
              end else begin
                st_q <= S_RD;
              end
              pass_q <= 1'b1;
            end else begin
              vi_q <= vi_q + 1'b1;
              st_q <= S_RD;
            end
          end else if (term_q == T_DEATH) begin
            acc_q <= acc_q + 40'($signed(mres[31:0]));
            fl_q <= fl_q | mres[32];
            term_q <= T_MIGR; st_q <= S_RD;
          end else begin
            tmp_q <= mres[31:0]; fl_q <= fl_q | mres[32];
            st_q <= S_MUL2;
          end
        end
        S_MUL2: st_q <= S_RND2;
        S_RND2: begin
          acc_q <= acc_q + 40'($signed(mres[31:0]));
          fl_q <= fl_q | mres[32];
          st_q <= S_RD;
          if (term_q == T_BIRTH) begin
            term_q <= T_DEATH;
          end else if (32'(vj_q) == STAGES - 1) begin
            term_q <= T_UPD;
          end else begin
            vj_q <= vj_q + 1'b1;
          end
        end
        S_OUT: st_q <= S_OUTW;
        S_OUTW: if (!out_v_q) begin
          out_v_q <= 1'b1; out_vx_q <= oc_q[2:0]; out_val_q <= q_rd;
          out_sat_q <= clip_q[AW'(oc_q)];
          out_last_q <= (32'(oc_q) == NOUT - 1);
          if (32'(oc_q) == NOUT - 1) begin
            st_q <= S_IDLE;
          end else begin
            oc_q <= oc_q + 1'b1; st_q <= S_OUT;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {5'd0, out_val_q, out_vx_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_sat_q;
endmodule

// ===== rtl/hcs_checker.sv =====
// ----------------------------------------------------------------------------
// hcs_checker
// Port-level checks of the Heun step block.
// ----------------------------------------------------------------------------
module hcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tuser_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output held item changed");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input taken while result pending");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[39:35] == 5'd0)
    else $error("padding not zero");
endmodule

bind heun_characteristic_step_top hcs_checker u_hcs_checker (.*);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream testbench of heun_characteristic_step_top. A scoreboard class keeps
// its own copy of the rates, the q vector and dt. For every accepted input
// item it computes the Heun step or read results. Each output item is checked
// field by field against the oldest pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
  logic [2:0]  vertex;
  logic [31:0] q_value;
  logic        last;
  logic        saturated;
} q_report_t;

class heun_scoreboard;
  localparam longint ONE = 64'sd16777216;
  longint    birth[8];
  longint    death[8];
  longint    migr[64];
  longint    qv[8];
  longint    dt;
  int        errors;
  q_report_t reports[$];

  function new();
    foreach (birth[i]) begin
      birth[i] = 0;
      death[i] = 0;
      qv[i] = 0;
    end
    foreach (migr[i]) migr[i] = 0;
    dt = 167772;
    errors = 0;
  endfunction

  function longint clip(longint v, inout bit fl);
    if (v > 64'sd2147483647) begin
      fl = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      fl = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function longint qmul(longint a, longint b, inout bit fl);
    longint p;
    p = a * b + 64'sd8388608;
    return clip(p >>> 24, fl);
  endfunction

  function void flow(input longint x[8], output longint f[8], inout bit flags[8]);
    longint acc;
    bit     fl;
    for (int i = 0; i < 8; i++) begin
      fl = 0;
      acc = qmul(qmul(birth[i], clip(x[i] - ONE, fl), fl), x[i], fl);
      acc += qmul(death[i], clip(ONE - x[i], fl), fl);
      for (int j = 0; j < 8; j++)
        acc += qmul(qmul(migr[i*8+j], clip(x[j] - ONE, fl), fl), x[i], fl);
      f[i] = clip(acc, fl);
      if (fl) flags[i] = 1;
    end
  endfunction

  function void note_input(logic [47:0] d);
    logic [2:0] act, row, col;
    longint     val, inc;
    longint     f1[8], f2[8], pred[8];
    bit         flags[8];
    bit         fl;
    q_report_t  r;
    act = d[2:0];
    row = d[5:3];
    col = d[8:6];
    val = longint'($signed(d[40:9]));
    case (act)
      hcs_pkg::ACT_BIRTH: birth[row] = val;
      hcs_pkg::ACT_DEATH: death[row] = val;
      hcs_pkg::ACT_MIGR:  migr[row*8+col] = val;
      hcs_pkg::ACT_Q:     qv[row] = val;
      hcs_pkg::ACT_STEP: begin
        foreach (flags[i]) flags[i] = 0;
        flow(qv, f1, flags);
        for (int i = 0; i < 8; i++) begin
          fl = 0;
          inc = qmul(f1[i], dt, fl);
          pred[i] = clip(qv[i] + inc, fl);
          if (fl) flags[i] = 1;
        end
        flow(pred, f2, flags);
        for (int i = 0; i < 8; i++) begin
          fl = 0;
          // half of the sum folded into the wider shift
          inc = ((f1[i] + f2[i]) * dt + ONE) >>> 25;
          qv[i] = clip(qv[i] + inc, fl);
          if (fl) flags[i] = 1;
          r.vertex = i[2:0];
          r.q_value = qv[i][31:0];
          r.last = (i == 7);
          r.saturated = flags[i];
          reports = {reports, r};
        end
      end
      hcs_pkg::ACT_READ: begin
        r.vertex = row;
        r.q_value = qv[row][31:0];
        r.last = 1;
        r.saturated = 0;
        reports = {reports, r};
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [39:0] d, logic last, logic user);
    q_report_t r;
    if (reports.size() == 0) begin
      $error("unexpected output item %h", d);
      errors++;
      return;
    end
    r = reports.pop_front();
    if (d[2:0] !== r.vertex) begin
      $error("vertex: expected %0d got %0d", r.vertex, d[2:0]);
      errors++;
    end
    if (d[34:3] !== r.q_value) begin
      $error("q_value: expected %h got %h", r.q_value, d[34:3]);
      errors++;
    end
    if (last !== r.last) begin
      $error("last: expected %0b got %0b", r.last, last);
      errors++;
    end
    if (user !== r.saturated) begin
      $error("saturated: expected %0b got %0b", r.saturated, user);
      errors++;
    end
  endfunction
endclass

module tb;
  import hcs_pkg::*;

  localparam int WATCHDOG = 40000;
  localparam int SETTLE   = 900;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we = 0;
  logic [30:0] cfg_wdata = '0;
  logic        s_valid = 0;
  logic        s_ready;
  logic [47:0] s_data = '0;
  logic        m_valid;
  logic        m_ready = 0;
  logic [39:0] m_data;
  logic        m_last;
  logic        m_user;

  int  idle_send = 0;
  int  idle_recv = 0;
  bit  hold_req = 0;
  bit  in_fire = 0;
  int  quiet = 0;
  int  sent = 0;

  heun_scoreboard sb = new();

  heun_characteristic_step_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready), .m_axis_tdata_o(m_data),
    .m_axis_tlast_o(m_last), .m_axis_tuser_o(m_user)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    in_fire <= s_valid && s_ready;
    if (s_valid && s_ready) sb.note_input(s_data);
    if (m_valid && m_ready) sb.check_result(m_data, m_last, m_user);
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver side, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      m_ready = 0;
      repeat (3000) @(negedge clk_i);
      hold_req = 0;
    end
    m_ready = ($urandom_range(99) >= idle_recv);
  end

  task automatic send(input logic [2:0] act, input logic [2:0] row,
                      input logic [2:0] col, input logic [31:0] val);
    while ($urandom_range(99) < idle_send) begin
      s_valid = 0;
      @(negedge clk_i);
    end
    s_valid = 1;
    s_data = {7'b0, val, col, row, act};
    do begin
      @(posedge clk_i);
      @(negedge clk_i);
    end while (!in_fire);
    s_valid = 0;
    sent++;
  endtask

  task automatic drain();
    s_valid = 0;
    while (sb.reports.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_dt(input logic [30:0] v);
    cfg_we = 1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we = 0;
    sb.dt = v;
  endtask

  function automatic logic [2:0] rnd3();
    return 3'($urandom);
  endfunction

  function automatic logic [31:0] rnd_rate();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
  endfunction

  function automatic logic [31:0] rnd_q();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(0, 32'h0100_0000);
  endfunction

  task automatic random_phase(input int n);
    int stop;
    stop = sent + n;
    while (sent < stop) begin
      if ($urandom_range(9) < 8) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(3))
            0: send(ACT_BIRTH, rnd3(), 3'd0, rnd_rate());
            1: send(ACT_DEATH, rnd3(), rnd3(), rnd_rate());
            2: send(ACT_MIGR, rnd3(), rnd3(), rnd_rate());
            default: send(ACT_Q, rnd3(), rnd3(), rnd_q());
          endcase
        end
        send(ACT_STEP, rnd3(), rnd3(), $urandom);
        if ($urandom_range(1)) send(ACT_READ, rnd3(), rnd3(), $urandom);
      end else begin
        send(rnd3(), rnd3(), rnd3(), $urandom);
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed part
    idle_send = 9;
    idle_recv = 81;
    set_dt(31'h7FFF_FFFF);
    send(ACT_READ, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send(ACT_STEP, 3'd0, 3'd0, 32'h0);
    send(ACT_BIRTH, 3'd0, 3'd7, 32'h7FFF_FFFF);
    send(ACT_DEATH, 3'd7, 3'd0, 32'h8000_0000);
    send(ACT_MIGR, 3'd0, 3'd7, 32'h7FFF_FFFF);
    send(ACT_MIGR, 3'd7, 3'd0, 32'h8000_0000);
    send(ACT_Q, 3'd0, 3'd0, 32'h8000_0000);
    send(ACT_Q, 3'd7, 3'd7, 32'h7FFF_FFFF);
    send(ACT_Q, 3'd3, 3'd5, 32'h0100_0000);
    send(3'd6, 3'd2, 3'd3, 32'hFFFF_FFFF);
    send(3'd7, 3'd5, 3'd4, 32'h5555_AAAA);
    send(ACT_STEP, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send(ACT_READ, 3'd0, 3'd0, 32'h0);
    send(ACT_READ, 3'd7, 3'd0, 32'h0);
    drain();
    set_dt(31'd0);
    send(ACT_BIRTH, 3'd2, 3'd0, 32'h0080_0000);
    send(ACT_Q, 3'd2, 3'd0, 32'h0080_0000);
    send(ACT_STEP, 3'd0, 3'd0, 32'h0);
    send(ACT_READ, 3'd2, 3'd0, 32'h0);

    drain();
    set_dt(31'd167772);
    random_phase(90);
    drain();
    set_dt(31'h7FFF_FFFF);
    idle_send = 81;
    idle_recv = 9;
    random_phase(90);
    drain();
    set_dt(31'd0);
    idle_send = 0;
    idle_recv = 0;
    hold_req = 1;
    random_phase(90);
    drain();
    set_dt(31'($urandom_range(1, 32'h0100_0000)));
    random_phase(90);
    drain();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
